>>> hdl/pwla_pkg.sv
package pwla_pkg;

    localparam int NUM_BINS  = 60;
    localparam int MAX_PAIRS = 256;

    localparam int ADDR_W = $clog2(MAX_PAIRS);
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int BIN_W  = 6;
    localparam int REM_W  = BIN_W + 1;
    localparam int WL_W   = 16;
    localparam int VAL_W  = 32;

    // Divider: 54-bit magnitude dividend, 18-bit divisor
    localparam int DIV_W = 54;
    localparam int DVS_W = 18;

    localparam logic [WL_W-1:0] RANGE_START_RST = 16'd25600;
    localparam logic [WL_W-1:0] RANGE_END_RST   = 16'd44800;

    localparam logic [0:0] CFG_RANGE_START = 1'b0;
    localparam logic [0:0] CFG_RANGE_END   = 1'b1;

    typedef struct packed {
        logic [WL_W-1:0]         wl;
        logic signed [VAL_W-1:0] val;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             ovf;
    } run_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] avg;
        logic [BIN_W-1:0]        bin;
        logic                    last;
        logic                    ovf;
        logic                    bad;
    } result_t;

endpackage

>>> hdl/pwla_store.sv
module pwla_store (
    input  logic                          clk,
    input  pwla_pkg::wr_req_t             wr,
    input  logic [pwla_pkg::ADDR_W-1:0]   rd_addr,
    output pwla_pkg::entry_t              rd_data
);

    pwla_pkg::entry_t mem [pwla_pkg::MAX_PAIRS];
    pwla_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/pwla_div.sv
module pwla_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pwla_pkg::DIV_W-1:0]   dividend,
    input  logic [pwla_pkg::DVS_W-1:0]   divisor,
    output logic                         busy,
    output logic                         done,
    output logic [pwla_pkg::DIV_W-1:0]   quotient,
    output logic [pwla_pkg::DVS_W-1:0]   remainder
);

    localparam int STEP_W = $clog2(pwla_pkg::DIV_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [pwla_pkg::DIV_W-1:0] quo_reg;
    logic [pwla_pkg::DVS_W-1:0] rem_reg;
    logic [pwla_pkg::DVS_W-1:0] dvs_reg;

    logic [pwla_pkg::DVS_W:0]   shifted;
    logic [pwla_pkg::DVS_W:0]   diff;
    logic                       ge;

    // One quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[pwla_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[pwla_pkg::DVS_W-1:0] : shifted[pwla_pkg::DVS_W-1:0];
            quo_reg  <= {quo_reg[pwla_pkg::DIV_W-2:0], ge};
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(pwla_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/pwla_front.sv
module pwla_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [15:0]                   wavelength,
    input  logic signed [31:0]            sample_value,
    input  logic                          final_pair,
    output pwla_pkg::wr_req_t             wr,
    output logic [pwla_pkg::ADDR_W-1:0]   rd_addr,
    input  pwla_pkg::entry_t              rd_data,
    output logic                          cmd_push,
    output pwla_pkg::run_cmd_t            cmd,
    input  logic                          run_done,
    output logic                          running
);

    typedef enum logic [1:0] {F_IDLE, F_READ, F_CMP, F_WAIT} fstate_t;

    fstate_t                     state_reg, state_next;
    logic [pwla_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        ovf_reg, ovf_next;
    logic [pwla_pkg::ADDR_W-1:0] pos_reg, pos_next;
    pwla_pkg::entry_t            new_reg, new_next;
    logic                        fin_reg, fin_next;
    logic                        accept;
    logic                        ins_done;
    logic                        stop;

    assign full    = state_reg != F_IDLE;
    assign accept  = push && !full;
    assign rd_addr = pos_reg - 1'b1;
    assign running = state_reg == F_WAIT;

    // Stop shifting once the entry below is ordered before the new pair
    assign stop = (rd_data.wl < new_reg.wl)
               || (rd_data.wl == new_reg.wl && $signed(rd_data.val) <= $signed(new_reg.val));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        new_next   = new_reg;
        fin_next   = fin_reg;
        wr         = '0;
        cmd_push   = 1'b0;
        cmd.count  = cnt_reg;
        cmd.ovf    = ovf_reg;
        ins_done   = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    new_next.wl  = wavelength;
                    new_next.val = sample_value;
                    fin_next     = final_pair;
                    pos_next     = cnt_reg[pwla_pkg::ADDR_W-1:0];
                    if (cnt_reg < pwla_pkg::CNT_W'(pwla_pkg::MAX_PAIRS))
                    begin
                        state_next = F_READ;
                    end
                    else
                    begin
                        // Store full: drop the pair, still start the run on a final one
                        ovf_next = 1'b1;
                        if (final_pair)
                        begin
                            cmd_push   = 1'b1;
                            cmd.ovf    = 1'b1;
                            state_next = F_WAIT;
                        end
                    end
                end
            end
            F_READ:
            begin
                if (pos_reg == '0)
                begin
                    wr.en    = 1'b1;
                    wr.addr  = pos_reg;
                    wr.data  = new_reg;
                    ins_done = 1'b1;
                end
                else
                begin
                    state_next = F_CMP;
                end
            end
            F_CMP:
            begin
                wr.en   = 1'b1;
                wr.addr = pos_reg;
                if (stop)
                begin
                    wr.data  = new_reg;
                    ins_done = 1'b1;
                end
                else
                begin
                    wr.data    = rd_data;
                    pos_next   = pos_reg - 1'b1;
                    state_next = F_READ;
                end
            end
            F_WAIT:
            begin
                if (run_done)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        if (ins_done)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (fin_reg)
            begin
                cmd_push   = 1'b1;
                cmd.count  = cnt_reg + 1'b1;
                state_next = F_WAIT;
            end
            else
            begin
                state_next = F_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            fin_reg   <= fin_next;
            pos_reg   <= pos_next;
            new_reg   <= new_next;
        end
    end

    a_write_only_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == F_READ || state_reg == F_CMP))
        else $error("store written outside insertion");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pwla_pkg::CNT_W'(pwla_pkg::MAX_PAIRS))
        else $error("pair count beyond capacity");

    a_cmd_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |=> state_reg == F_WAIT)
        else $error("run command without waiting for the run");

endmodule

>>> hdl/pwla_cmdq.sv
module pwla_cmdq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pwla_pkg::run_cmd_t   din,
    input  logic                 pop,
    output logic                 valid,
    output pwla_pkg::run_cmd_t   dout
);

    pwla_pkg::run_cmd_t slot_reg [2];
    logic               wp_reg;
    logic               rp_reg;
    logic [1:0]         fill_reg;
    logic               do_push;
    logic               do_pop;

    assign do_push = push && fill_reg != 2'd2;
    assign do_pop  = pop && fill_reg != 2'd0;
    assign valid   = fill_reg != 2'd0;
    assign dout    = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wp_reg] <= din;
                wp_reg           <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            fill_reg <= fill_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

>>> hdl/pwla_back.sv
module pwla_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [15:0]                   range_start,
    input  logic [15:0]                   range_end,
    input  logic                          cmd_valid,
    input  pwla_pkg::run_cmd_t            cmd,
    output logic                          cmd_pop,
    output logic [pwla_pkg::ADDR_W-1:0]   rd_addr,
    input  pwla_pkg::entry_t              rd_data,
    output logic                          run_done,
    output logic                          empty,
    input  logic                          pop,
    output pwla_pkg::result_t             res
);

    localparam int PROD_W = 53;
    localparam int SUM_W  = pwla_pkg::DIV_W + 1;
    localparam int PT_W   = 34;
    // ceil(2^22 / NUM_BINS): exact quotient for every 16-bit span
    localparam logic [22:0] RECIP_BINS =
        23'((2**22 + pwla_pkg::NUM_BINS - 1) / pwla_pkg::NUM_BINS);

    typedef enum logic [4:0] {
        B_IDLE, B_RD_FIRST, B_RD_LAST, B_SPAN, B_SPAN_WAIT, B_BIN, B_FLAT_LO, B_FLAT_HI,
        B_SEG_RD, B_SEG_CHK, B_SEG_EVAL, B_PT_MUL, B_PT_DIV, B_PT_WAIT, B_SEG_MUL,
        B_SEG_ADD, B_FIN_DIV, B_FIN_WAIT, B_EMIT
    } bstate_t;

    typedef enum logic [1:0] {PT_S, PT_E, PT_ZERO} pt_t;

    bstate_t                      state_reg;
    pt_t                          phase_reg;
    logic [pwla_pkg::CNT_W-1:0]   n_reg;
    logic [pwla_pkg::CNT_W-1:0]   k_reg;
    logic                         ovf_reg;
    logic                         bad_reg;
    logic                         zero_reg;
    logic                         neg_reg;
    pwla_pkg::entry_t             first_reg, last_reg, prev_reg, cur_reg;
    logic [15:0]                  span_q_reg;
    logic [pwla_pkg::REM_W-1:0]   span_r_reg;
    logic [15:0]                  lo_off_reg;
    logic [pwla_pkg::REM_W-1:0]   lo_rem_reg;
    logic [pwla_pkg::BIN_W-1:0]   bin_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [PT_W-1:0]       vs_reg;
    logic signed [PT_W-1:0]       ve_reg;
    logic signed [31:0]           avg_reg;
    logic                         out_valid_reg;
    pwla_pkg::result_t            res_reg;

    logic [15:0]                  span;
    logic                         bad;
    logic [38:0]                  recip_prod;
    logic [15:0]                  span_quo;
    logic [15:0]                  span_rem;
    logic [pwla_pkg::REM_W-1:0]   hi_rem_sum;
    logic                         wrap;
    logic [15:0]                  hi_off;
    logic [pwla_pkg::REM_W-1:0]   hi_rem;
    logic [16:0]                  lo, hi;
    logic [16:0]                  first_w, last_w, prev_w, cur_w;
    logic [16:0]                  seg_s, seg_e, pt, off;
    logic signed [32:0]           dv;
    logic signed [34:0]           mul_a;
    logic signed [17:0]           mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic signed [SUM_W-1:0]      sum_abs_src;
    logic                         div_start;
    logic [pwla_pkg::DIV_W-1:0]   div_dividend;
    logic [pwla_pkg::DVS_W-1:0]   div_divisor;
    logic                         div_busy;
    logic                         div_done;
    logic [pwla_pkg::DIV_W-1:0]   div_quo;
    logic [pwla_pkg::DVS_W-1:0]   div_rem;
    logic signed [SUM_W-1:0]      q_adj;
    logic signed [SUM_W-1:0]      fq;
    logic signed [PT_W-1:0]       pt_val;
    logic                         sat;
    logic signed [31:0]           fin_avg;
    logic                         seg_last;
    logic                         emit_load;
    logic                         last_bin;

    // Bin edges: advance quotient and remainder of i*span/NUM_BINS
    assign span       = range_end - range_start;
    assign bad        = range_start >= range_end;
    assign recip_prod = span * RECIP_BINS;
    assign span_quo   = recip_prod[37:22];
    assign span_rem   = span - span_q_reg * 16'(pwla_pkg::NUM_BINS);
    assign hi_rem_sum = lo_rem_reg + span_r_reg;
    assign wrap       = hi_rem_sum >= pwla_pkg::REM_W'(pwla_pkg::NUM_BINS);
    assign hi_off     = lo_off_reg + span_q_reg + {15'd0, wrap};
    assign hi_rem     = wrap ? hi_rem_sum - pwla_pkg::REM_W'(pwla_pkg::NUM_BINS) : hi_rem_sum;
    assign lo         = {1'b0, range_start} + {1'b0, lo_off_reg};
    assign hi         = {1'b0, range_start} + {1'b0, hi_off};

    assign first_w = {1'b0, first_reg.wl};
    assign last_w  = {1'b0, last_reg.wl};
    assign prev_w  = {1'b0, prev_reg.wl};
    assign cur_w   = {1'b0, cur_reg.wl};
    assign seg_s   = lo > prev_w ? lo : prev_w;
    assign seg_e   = hi < cur_w ? hi : cur_w;
    assign pt      = (phase_reg == PT_E) ? seg_e : ((phase_reg == PT_S) ? seg_s : lo);
    assign off     = pt - prev_w;
    assign dv      = $signed({cur_reg.val[31], cur_reg.val})
                   - $signed({prev_reg.val[31], prev_reg.val});

    // Shared multiplier, operands picked by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_BIN:
            begin
                mul_a = 35'(first_reg.val);
                mul_b = (lo < first_w) ? $signed({1'b0, first_w - lo}) : 18'sd0;
            end
            B_FLAT_LO:
            begin
                mul_a = 35'(last_reg.val);
                mul_b = (hi > last_w) ? $signed({1'b0, hi - last_w}) : 18'sd0;
            end
            B_PT_MUL:
            begin
                mul_a = 35'(dv);
                mul_b = $signed({1'b0, off});
            end
            B_SEG_MUL:
            begin
                mul_a = 35'(vs_reg) + 35'(ve_reg);
                mul_b = $signed({1'b0, seg_e - seg_s});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider feed: magnitude in, sign kept aside
    assign sum_abs_src = (state_reg == B_FIN_DIV) ? sum_reg : SUM_W'(prod_reg);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            B_PT_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = sum_abs_src[SUM_W-1] ? pwla_pkg::DIV_W'(-sum_abs_src)
                                                    : pwla_pkg::DIV_W'(sum_abs_src);
                div_divisor  = pwla_pkg::DVS_W'(cur_w - prev_w);
            end
            B_FIN_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = sum_abs_src[SUM_W-1] ? pwla_pkg::DIV_W'(-sum_abs_src)
                                                    : pwla_pkg::DIV_W'(sum_abs_src);
                div_divisor  = {hi - lo, 1'b0};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    pwla_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Floor of a signed quotient
    assign q_adj  = $signed({1'b0, div_quo})
                  + $signed({{(SUM_W-1){1'b0}}, (neg_reg && div_rem != '0)});
    assign fq     = neg_reg ? -q_adj : q_adj;
    assign pt_val = 34'(prev_reg.val) + fq[PT_W-1:0];
    assign sat    = !((&fq[SUM_W-1:31]) || !(|fq[SUM_W-1:31]));
    assign fin_avg = sat ? (fq[SUM_W-1] ? 32'sh80000000 : 32'sh7fffffff) : fq[31:0];

    assign seg_last  = k_reg == (n_reg - 1'b1);
    assign last_bin  = bin_reg == pwla_pkg::BIN_W'(pwla_pkg::NUM_BINS - 1);
    assign emit_load = (state_reg == B_EMIT) && (!out_valid_reg || pop);
    assign run_done  = emit_load && last_bin;
    assign cmd_pop   = (state_reg == B_IDLE) && cmd_valid;

    always_comb
    begin
        case (state_reg)
            B_RD_LAST: rd_addr = pwla_pkg::ADDR_W'(n_reg - 1'b1);
            B_SEG_RD:  rd_addr = k_reg[pwla_pkg::ADDR_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
                res_reg.avg   <= avg_reg;
                res_reg.bin   <= bin_reg;
                res_reg.last  <= last_bin;
                res_reg.ovf   <= ovf_reg;
                res_reg.bad   <= bad_reg;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        n_reg      <= cmd.count;
                        ovf_reg    <= cmd.ovf;
                        bad_reg    <= bad;
                        bin_reg    <= '0;
                        lo_off_reg <= '0;
                        lo_rem_reg <= '0;
                        state_reg  <= B_RD_FIRST;
                    end
                end
                B_RD_FIRST:
                begin
                    state_reg <= B_RD_LAST;
                end
                B_RD_LAST:
                begin
                    first_reg <= rd_data;
                    state_reg <= B_SPAN;
                end
                B_SPAN:
                begin
                    last_reg   <= rd_data;
                    span_q_reg <= span_quo;
                    state_reg  <= B_SPAN_WAIT;
                end
                B_SPAN_WAIT:
                begin
                    span_r_reg <= span_rem[pwla_pkg::REM_W-1:0];
                    state_reg  <= B_BIN;
                end
                B_BIN:
                begin
                    prod_reg <= mul_p;
                    prev_reg <= first_reg;
                    k_reg    <= pwla_pkg::CNT_W'(1);
                    zero_reg <= lo == hi;
                    if (bad_reg)
                    begin
                        avg_reg   <= '0;
                        state_reg <= B_EMIT;
                    end
                    else if (n_reg == pwla_pkg::CNT_W'(1) || hi <= first_w)
                    begin
                        avg_reg   <= first_reg.val;
                        state_reg <= B_EMIT;
                    end
                    else if (lo >= last_w)
                    begin
                        avg_reg   <= last_reg.val;
                        state_reg <= B_EMIT;
                    end
                    else if (lo == hi)
                    begin
                        state_reg <= B_SEG_RD;
                    end
                    else
                    begin
                        state_reg <= B_FLAT_LO;
                    end
                end
                B_FLAT_LO:
                begin
                    sum_reg   <= SUM_W'(prod_reg) <<< 1;
                    prod_reg  <= mul_p;
                    state_reg <= B_FLAT_HI;
                end
                B_FLAT_HI:
                begin
                    sum_reg   <= sum_reg + (SUM_W'(prod_reg) <<< 1);
                    state_reg <= B_SEG_RD;
                end
                B_SEG_RD:
                begin
                    state_reg <= B_SEG_CHK;
                end
                B_SEG_CHK:
                begin
                    cur_reg   <= rd_data;
                    state_reg <= B_SEG_EVAL;
                end
                B_SEG_EVAL:
                begin
                    if (zero_reg && prev_w <= lo && lo < cur_w)
                    begin
                        phase_reg <= PT_ZERO;
                        state_reg <= B_PT_MUL;
                    end
                    else if (!zero_reg && seg_s < seg_e)
                    begin
                        phase_reg <= PT_S;
                        state_reg <= B_PT_MUL;
                    end
                    else
                    begin
                        // Skip this segment
                        prev_reg <= cur_reg;
                        k_reg    <= k_reg + 1'b1;
                        if (seg_last)
                        begin
                            avg_reg   <= last_reg.val;
                            state_reg <= zero_reg ? B_EMIT : B_FIN_DIV;
                        end
                        else
                        begin
                            state_reg <= B_SEG_RD;
                        end
                    end
                end
                B_PT_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_PT_DIV;
                end
                B_PT_DIV:
                begin
                    neg_reg   <= prod_reg[PROD_W-1];
                    state_reg <= B_PT_WAIT;
                end
                B_PT_WAIT:
                begin
                    if (div_done)
                    begin
                        case (phase_reg)
                            PT_ZERO:
                            begin
                                avg_reg   <= pt_val[31:0];
                                state_reg <= B_EMIT;
                            end
                            PT_S:
                            begin
                                vs_reg    <= pt_val;
                                phase_reg <= PT_E;
                                state_reg <= B_PT_MUL;
                            end
                            default:
                            begin
                                ve_reg    <= pt_val;
                                state_reg <= B_SEG_MUL;
                            end
                        endcase
                    end
                end
                B_SEG_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_SEG_ADD;
                end
                B_SEG_ADD:
                begin
                    sum_reg  <= sum_reg + SUM_W'(prod_reg);
                    prev_reg <= cur_reg;
                    k_reg    <= k_reg + 1'b1;
                    state_reg <= seg_last ? B_FIN_DIV : B_SEG_RD;
                end
                B_FIN_DIV:
                begin
                    neg_reg   <= sum_reg[SUM_W-1];
                    state_reg <= B_FIN_WAIT;
                end
                B_FIN_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= fin_avg;
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT:
                begin
                    if (emit_load)
                    begin
                        if (last_bin)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            bin_reg    <= bin_reg + 1'b1;
                            lo_off_reg <= hi_off;
                            lo_rem_reg <= hi_rem;
                            state_reg  <= B_BIN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign empty = !out_valid_reg;
    assign res   = res_reg;

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_done_on_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        run_done |-> bin_reg == pwla_pkg::BIN_W'(pwla_pkg::NUM_BINS - 1))
        else $error("run ended before the last bin");

    a_bin_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && !last_bin) |=> bin_reg == pwla_pkg::BIN_W'($past(bin_reg) + 1'b1))
        else $error("bin number skipped");

endmodule

>>> hdl/piecewise_linear_bin_averager.sv
// Piecewise-linear spectrum bin averager.
//
// Input channel (push/full): one (wavelength, sample_value) beat per pair, in
// any order; final_pair marks the last pair of a set and starts the run.
// Each pair is placed by insertion into a sorted store: a read/compare/write
// loop on the store shifts up each stored entry that sorts after it, then
// writes the pair into the gap. full stays high during insertion and for
// the whole run that follows a final pair.
// Result channel (empty/pop): NUM_BINS beats per run, bins in order, the last
// one flagged with last_bin. A bin outside the samples needs no division;
// otherwise each sample segment that it overlaps takes two divisions and
// the bin a closing one (a zero-width bin takes one division in all), on
// the shared serial divider (one quotient bit per cycle, DIV_W = 54).
// Configuration (cfg_we/cfg_index/cfg_data): range_start and range_end, taken
// the cycle cfg_we is high; write only while no set is loading or running.
// Reset clears the pair count, the overflow flag, queues and output valid flag;
// the range registers return to 400 nm and 700 nm.
// A stalled receiver (pop low) holds the current result and stalls the run.
module piecewise_linear_bin_averager (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        wavelength,
    input  logic signed [31:0] sample_value,
    input  logic               final_pair,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] bin_average,
    output logic [5:0]         bin_number,
    output logic               last_bin,
    output logic               overflowed,
    output logic               range_invalid
);

    logic [15:0]                 range_start_reg;
    logic [15:0]                 range_end_reg;
    pwla_pkg::wr_req_t           wr;
    logic [pwla_pkg::ADDR_W-1:0] front_rd_addr;
    logic [pwla_pkg::ADDR_W-1:0] back_rd_addr;
    logic [pwla_pkg::ADDR_W-1:0] store_rd_addr;
    pwla_pkg::entry_t            rd_data;
    logic                        cmd_push;
    pwla_pkg::run_cmd_t          cmd_in;
    logic                        cmd_valid;
    pwla_pkg::run_cmd_t          cmd_out;
    logic                        cmd_pop;
    logic                        run_done;
    logic                        running;
    pwla_pkg::result_t           res;

    // Range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= pwla_pkg::RANGE_START_RST;
            range_end_reg   <= pwla_pkg::RANGE_END_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pwla_pkg::CFG_RANGE_START)
            begin
                range_start_reg <= cfg_data;
            end
            if (cfg_index == pwla_pkg::CFG_RANGE_END)
            begin
                range_end_reg <= cfg_data;
            end
        end
    end

    // Front: take beats, keep the store sorted
    pwla_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .wavelength   (wavelength),
        .sample_value (sample_value),
        .final_pair   (final_pair),
        .wr           (wr),
        .rd_addr      (front_rd_addr),
        .rd_data      (rd_data),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in),
        .run_done     (run_done),
        .running      (running)
    );

    // The back side owns the read port for the length of a run
    assign store_rd_addr = running ? back_rd_addr : front_rd_addr;

    pwla_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (store_rd_addr),
        .rd_data (rd_data)
    );

    // Run commands between the two sides
    pwla_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .valid (cmd_valid),
        .dout  (cmd_out)
    );

    // Back: per-bin integration and output register
    pwla_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_start (range_start_reg),
        .range_end   (range_end_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd_out),
        .cmd_pop     (cmd_pop),
        .rd_addr     (back_rd_addr),
        .rd_data     (rd_data),
        .run_done    (run_done),
        .empty       (empty),
        .pop         (pop),
        .res         (res)
    );

    assign bin_average   = res.avg;
    assign bin_number    = res.bin;
    assign last_bin      = res.last;
    assign overflowed    = res.ovf;
    assign range_invalid = res.bad;

endmodule

>>> dv/tb_piecewise_linear_bin_averager.sv
module tb_piecewise_linear_bin_averager;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 6000000;
    // Longest quiet time after the last bin before the block counts as idle.
    localparam int DRAIN_CYCLES = 600;

    // Sorted-store model of the averager: tracks the stored pairs and the range
    // registers, and predicts every bin beat produced by a final pair.
    class bin_scoreboard;
        logic [pwla_pkg::WL_W-1:0] range_lo_reg;
        logic [pwla_pkg::WL_W-1:0] range_hi_reg;
        longint                    sorted_wl[pwla_pkg::MAX_PAIRS];
        longint                    sorted_val[pwla_pkg::MAX_PAIRS];
        int                        pairs_held;
        bit                        dropped_pair;
        pwla_pkg::result_t         bins_due[$];
        int                        errors;

        function void reset_state();
            range_lo_reg = pwla_pkg::RANGE_START_RST;
            range_hi_reg = pwla_pkg::RANGE_END_RST;
            pairs_held   = 0;
            dropped_pair = 0;
            bins_due.delete();
            errors       = 0;
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function longint floor_quot(longint num, longint den);
            longint q;
            q = num / den;
            if ((num % den) != 0 && num < 0)
                q = q - 1;
            return q;
        endfunction

        // Interpolant on segment k evaluated at wavelength w.
        function longint interp(int k, longint w);
            return sorted_val[k] + floor_quot((sorted_val[k+1] - sorted_val[k]) *
                (w - sorted_wl[k]), sorted_wl[k+1] - sorted_wl[k]);
        endfunction

        function longint bin_mean(longint lo, longint hi);
            longint first_wl;
            longint last_wl;
            longint acc;
            longint s;
            longint e;
            first_wl = sorted_wl[0];
            last_wl  = sorted_wl[pairs_held-1];
            acc      = 0;
            if (pairs_held == 1 || hi <= first_wl)
                return sorted_val[0];
            if (lo >= last_wl)
                return sorted_val[pairs_held-1];
            if (lo == hi)
            begin
                for (int k = 0; k + 1 < pairs_held; k++)
                    if (sorted_wl[k] <= lo && lo < sorted_wl[k+1])
                        return interp(k, lo);
                return sorted_val[pairs_held-1];
            end
            if (lo < first_wl)
                acc += 2 * sorted_val[0] * (first_wl - lo);
            if (hi > last_wl)
                acc += 2 * sorted_val[pairs_held-1] * (hi - last_wl);
            for (int k = 0; k + 1 < pairs_held; k++)
            begin
                s = (lo > sorted_wl[k]) ? lo : sorted_wl[k];
                e = (hi < sorted_wl[k+1]) ? hi : sorted_wl[k+1];
                // zero-width segments drop out here since s == e
                if (s < e)
                    acc += (interp(k, s) + interp(k, e)) * (e - s);
            end
            return floor_quot(acc, 2 * (hi - lo));
        endfunction

        function void write_range(logic [0:0] idx, logic [pwla_pkg::WL_W-1:0] data);
            if (idx == pwla_pkg::CFG_RANGE_START)
                range_lo_reg = data;
            else
                range_hi_reg = data;
        endfunction

        // Note one accepted input beat; a final pair queues all bin beats.
        function void note_pair(logic [pwla_pkg::WL_W-1:0] w,
                                logic signed [pwla_pkg::VAL_W-1:0] v, bit fin);
            int                pos;
            bit                bad;
            longint            span;
            longint            lo;
            longint            hi;
            longint            avg;
            pwla_pkg::result_t r;
            if (pairs_held < pwla_pkg::MAX_PAIRS)
            begin
                pos = pairs_held;
                while (pos > 0 && (sorted_wl[pos-1] > w ||
                       (sorted_wl[pos-1] == w && sorted_val[pos-1] > v)))
                begin
                    sorted_wl[pos]  = sorted_wl[pos-1];
                    sorted_val[pos] = sorted_val[pos-1];
                    pos--;
                end
                sorted_wl[pos]  = w;
                sorted_val[pos] = v;
                pairs_held++;
            end
            else
                dropped_pair = 1;
            if (!fin)
                return;
            bad  = range_lo_reg >= range_hi_reg;
            span = bad ? 0 : longint'(range_hi_reg) - longint'(range_lo_reg);
            for (int b = 0; b < pwla_pkg::NUM_BINS; b++)
            begin
                avg = 0;
                if (!bad)
                begin
                    lo  = longint'(range_lo_reg) + (b * span) / pwla_pkg::NUM_BINS;
                    hi  = longint'(range_lo_reg) + ((b + 1) * span) / pwla_pkg::NUM_BINS;
                    avg = bin_mean(lo, hi);
                    if (avg > 64'sd2147483647)
                        avg = 64'sd2147483647;
                    if (avg < -64'sd2147483648)
                        avg = -64'sd2147483648;
                end
                r.avg  = avg[31:0];
                r.bin  = b[pwla_pkg::BIN_W-1:0];
                r.last = (b == pwla_pkg::NUM_BINS - 1);
                r.ovf  = dropped_pair;
                r.bad  = bad;
                bins_due.push_back(r);
            end
            pairs_held   = 0;
            dropped_pair = 0;
        endfunction

        function void check_bin(pwla_pkg::result_t got);
            pwla_pkg::result_t want;
            if (bins_due.size() == 0)
            begin
                report($sformatf("unexpected bin beat, bin %0d", got.bin));
                return;
            end
            want = bins_due.pop_front();
            if (got.avg !== want.avg)
                report($sformatf("bin %0d average %0d, want %0d", want.bin, got.avg, want.avg));
            if (got.bin !== want.bin)
                report($sformatf("bin_number %0d, want %0d", got.bin, want.bin));
            if (got.last !== want.last)
                report($sformatf("bin %0d last_bin %b, want %b", want.bin, got.last, want.last));
            if (got.ovf !== want.ovf)
                report($sformatf("bin %0d overflowed %b, want %b", want.bin, got.ovf, want.ovf));
            if (got.bad !== want.bad)
                report($sformatf("bin %0d range_invalid %b, want %b", want.bin, got.bad, want.bad));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [15:0]        wavelength;
    logic signed [31:0] sample_value;
    logic               final_pair;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               empty;
    logic               pop;
    logic signed [31:0] bin_average;
    logic [5:0]         bin_number;
    logic               last_bin;
    logic               overflowed;
    logic               range_invalid;

    bin_scoreboard sb;
    int unsigned   cycle_count;
    bit            steady;        // no idling on either side while set
    bit            pressure_req;  // ask the receiver for one long hold-off

    piecewise_linear_bin_averager i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .wavelength    (wavelength),
        .sample_value  (sample_value),
        .final_pair    (final_pair),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .empty         (empty),
        .pop           (pop),
        .bin_average   (bin_average),
        .bin_number    (bin_number),
        .last_bin      (last_bin),
        .overflowed    (overflowed),
        .range_invalid (range_invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if it never drains.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[piecewise_linear_bin_averager] ERROR");
                $finish;
            end
        end
    end

    // Receiver: pop at random, hold off once for a long stretch on request,
    // and check every accepted bin beat at the rising edge.
    initial
    begin
        int                hold_left;
        bit                hold_done;
        pwla_pkg::result_t got;
        hold_left = 0;
        hold_done = 0;
        pop       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_req && !hold_done)
            begin
                hold_left = 4000;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else
                pop = steady || ($urandom_range(99) >= 18);
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.avg  = bin_average;
                got.bin  = bin_number;
                got.last = last_bin;
                got.ovf  = overflowed;
                got.bad  = range_invalid;
                sb.check_bin(got);
            end
        end
    end

    // Offer one pair and hold it until the block takes it.
    task automatic send_pair(logic [15:0] w, logic signed [31:0] v, bit fin);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 18)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        wavelength   = w;
        sample_value = v;
        final_pair   = fin;
        push         = 1'b1;
        do
            @(posedge clk);
        while (full);
        sb.note_pair(w, v, fin);
    endtask

    // Let all bins drain and the block settle, then write both range registers.
    task automatic set_range(logic [15:0] lo, logic [15:0] hi);
        @(negedge clk);
        push = 1'b0;
        while (sb.bins_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = pwla_pkg::CFG_RANGE_START;
        cfg_data  = lo;
        sb.write_range(pwla_pkg::CFG_RANGE_START, lo);
        @(negedge clk);
        cfg_index = pwla_pkg::CFG_RANGE_END;
        cfg_data  = hi;
        sb.write_range(pwla_pkg::CFG_RANGE_END, hi);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(4000000)) - 32'sd2000000;
            default: return $urandom();
        endcase
    endfunction

    // Wavelength mostly around the active range, sometimes anywhere.
    function automatic logic [15:0] pick_wavelength(int lo, int hi);
        int margin;
        int a;
        int b;
        if ($urandom_range(7) == 0 || lo >= hi)
            return 16'($urandom_range(65535));
        margin = (hi - lo) / 4 + 2;
        a = (lo - margin < 0) ? 0 : lo - margin;
        b = (hi + margin > 65535) ? 65535 : hi + margin;
        return 16'($urandom_range(b, a));
    endfunction

    // One set of random pairs, with repeated wavelengths now and then.
    task automatic send_random_set(int lo, int hi);
        int          n;
        logic [15:0] w;
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        w = pick_wavelength(lo, hi);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(4) != 0)
                w = pick_wavelength(lo, hi);
            send_pair(w, pick_value(), k == n - 1);
        end
    endtask

    initial
    begin
        int lo;
        int hi;
        sb = new();
        sb.reset_state();
        steady       = 0;
        pressure_req = 0;
        rst_n        = 1'b0;
        push         = 1'b0;
        wavelength   = '0;
        sample_value = '0;
        final_pair   = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = pwla_pkg::CFG_RANGE_START;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sets at the reset range (400..700 nm).
        // Single sample: every bin takes its value.
        send_pair(16'd32000, 32'sh7fffffff, 1);
        // Samples only inside part of the range: flat ends on both sides,
        // with a tie on wavelength given in reverse value order.
        send_pair(16'd40000, 32'sh80000000, 0);
        send_pair(16'd30000, 32'sd65536, 0);
        send_pair(16'd30000, -32'sd65536, 0);
        send_pair(16'd35000, 32'sh7fffffff, 1);
        // All samples left, then all right of the range.
        send_pair(16'd0, 32'sd12345, 0);
        send_pair(16'd100, -32'sd777, 1);
        send_pair(16'd65535, 32'sh80000000, 0);
        send_pair(16'd60000, 32'sh7fffffff, 1);
        // Extremes swing across one bin.
        send_pair(16'd25600, 32'sh80000000, 0);
        send_pair(16'd25700, 32'sh7fffffff, 1);

        // Full store: 256 ascending pairs, then a dropped final pair.
        set_range(16'd0, 16'd65535);
        for (int k = 0; k < pwla_pkg::MAX_PAIRS; k++)
            send_pair(16'(k * 256), $urandom(), 0);
        send_pair(16'd65535, 32'sd5, 1);
        // Overflow flag must clear for the next set.
        send_pair(16'd0, -32'sd1, 0);
        send_pair(16'd65535, 32'sd1, 1);

        // Narrow range: zero-width bins inside the samples.
        set_range(16'd1000, 16'd1030);
        send_pair(16'd990, 32'sd1000000, 0);
        send_pair(16'd1015, -32'sd3000000, 0);
        send_pair(16'd1040, 32'sd7, 1);

        // Invalid ranges: equal bounds, then start above end.
        set_range(16'd500, 16'd500);
        send_pair(16'd500, 32'sd9, 1);
        set_range(16'd65535, 16'd0);
        send_pair(16'd100, 32'sd9, 0);
        send_pair(16'd200, -32'sd9, 1);

        // Random sets under several ranges; the second phase runs with no idling,
        // and the first asks for the long receiver hold-off so the input stalls.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin lo = 25600; hi = 44800; end
                1: begin lo = 0;     hi = 65535; end
                2: begin lo = 2000;  hi = 2050;  end
                3: begin lo = 30000; hi = 30000; end
                default:
                begin
                    lo = $urandom_range(60000);
                    hi = lo + $urandom_range(65535 - lo, 1);
                end
            endcase
            set_range(16'(lo), 16'(hi));
            steady = (phase == 1);
            for (int s = 0; s < 4; s++)
            begin
                send_random_set(lo, hi);
                if (phase == 0 && s == 0)
                    pressure_req = 1;
            end
            steady = 0;
        end

        // Drain: wait for every bin, then let the block settle.
        @(negedge clk);
        push = 1'b0;
        while (sb.bins_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.bins_due.size() != 0)
            sb.report("bins still expected at end of run");
        if (sb.errors == 0)
            $display("[piecewise_linear_bin_averager] OK");
        else
            $display("[piecewise_linear_bin_averager] ERROR");
        $finish;
    end

endmodule
